>>> rtl/deq_pkg.sv
package deq_pkg;

  // Fixed field widths of the stream payload.
  localparam int ELEMENT_W = 16;
  localparam int STATUS_W  = 2;
  localparam int OP_W      = 2;

  // Defaults for the top-level parameters.
  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_VALUE_BITS = 16;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_REVERSE = 2'd1,
    OP_DELETE  = 2'd2,
    OP_FINISH  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ELEMENT  = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_ERROR    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // Strobes from the controller to the element store.
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_ctl_t;

endpackage

>>> rtl/deq_store.sv
module deq_store #(
  parameter int CAPACITY  = 64,
  parameter int DATA_BITS = 16,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                  clk,
  input  deq_pkg::mem_ctl_t     ctl,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_BITS-1:0]  wr_data,
  input  logic [AW-1:0]         rd_addr,
  output logic [DATA_BITS-1:0]  rd_data
);
  import deq_pkg::*;

  logic [DATA_BITS-1:0] mem [CAPACITY];

  // Read data holds until the next read, so the controller can park it.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/deq_ctrl.sv
module deq_ctrl #(
  parameter int CAPACITY  = 64,
  parameter int DATA_BITS = 16,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [deq_pkg::ELEMENT_W-1:0] s_tdata,
  input  logic [deq_pkg::OP_W-1:0]      s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [deq_pkg::ELEMENT_W-1:0] m_tdata,
  output logic [deq_pkg::STATUS_W-1:0]  m_tuser,
  output logic                          m_tlast,
  output deq_pkg::mem_ctl_t             mem_ctl,
  output logic [AW-1:0]                 wr_addr,
  output logic [DATA_BITS-1:0]          wr_data,
  output logic [AW-1:0]                 rd_addr,
  input  logic [DATA_BITS-1:0]          rd_data
);
  import deq_pkg::*;

  typedef enum logic {IDLE, EMIT} state_t;

  state_t          state;
  logic [AW-1:0]   head;
  logic [CW-1:0]   count;
  logic            rev;
  logic            err;
  logic            ovf;
  status_t         mode;
  logic [CW-1:0]   idx;
  logic            pend;
  logic            pend_last;
  logic            out_valid;
  logic [ELEMENT_W-1:0] out_data;
  status_t         out_status;
  logic            out_last;

  logic            accept;
  op_t             op;
  logic            out_free;
  logic            issue;
  logic            move;
  logic            stat_go;
  logic [CW-1:0]   off;

  // Physical slot of a logical offset from the head, wrapped by one
  // compare and subtract as base < CAPACITY and offset <= CAPACITY.
  function automatic logic [AW-1:0] wrap_slot(input logic [AW-1:0] base,
                                               input logic [CW-1:0] ofs);
    logic [AW:0] sum;
    sum = (AW+1)'(base) + (AW+1)'(ofs);
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign op       = op_t'(s_tuser);
  assign out_free = !out_valid || m_tready;

  assign issue   = (state == EMIT) && (mode == ST_ELEMENT) && (idx != count)
                   && (!pend || out_free);
  assign move    = pend && out_free;
  assign stat_go = (state == EMIT) && (mode != ST_ELEMENT) && out_free;

  assign off     = rev ? (count - CW'(1) - idx) : idx;
  assign rd_addr = wrap_slot(head, off);
  assign wr_addr = wrap_slot(head, count);
  assign wr_data = s_tdata[DATA_BITS-1:0];

  assign mem_ctl.wr = accept && (op == OP_LOAD) && (count != CW'(CAPACITY));
  assign mem_ctl.rd = issue;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      head      <= '0;
      count     <= '0;
      rev       <= 1'b0;
      err       <= 1'b0;
      ovf       <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= move || stat_go;
      end
      if (move) begin
        out_data   <= ELEMENT_W'(rd_data);
        out_status <= ST_ELEMENT;
        out_last   <= pend_last;
      end else if (stat_go) begin
        out_data   <= '0;
        out_status <= mode;
        out_last   <= 1'b1;
      end

      if (issue) begin
        pend      <= 1'b1;
        pend_last <= (idx == count - CW'(1));
        idx       <= idx + CW'(1);
      end else if (move) begin
        pend <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (accept) begin
            case (op)
              OP_LOAD: begin
                if (count == CW'(CAPACITY)) begin
                  ovf <= 1'b1;
                end else begin
                  count <= count + CW'(1);
                end
              end
              OP_REVERSE: begin
                rev <= !rev;
              end
              OP_DELETE: begin
                if (!err) begin
                  if (count == '0) begin
                    err <= 1'b1;
                  end else begin
                    if (!rev) begin
                      head <= wrap_slot(head, CW'(1));
                    end
                    count <= count - CW'(1);
                  end
                end
              end
              OP_FINISH: begin
                idx   <= '0;
                state <= EMIT;
                if (err) begin
                  mode <= ST_ERROR;
                end else if (ovf) begin
                  mode <= ST_OVERFLOW;
                end else if (count == '0) begin
                  mode <= ST_EMPTY;
                end else begin
                  mode <= ST_ELEMENT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        EMIT: begin
          if (stat_go || (move && pend_last)) begin
            state <= IDLE;
            head  <= '0;
            count <= '0;
            rev   <= 1'b0;
            err   <= 1'b0;
            ovf   <= 1'b0;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/reversible_deque_engine.sv
// Reversible deque engine. Each input transfer carries an operation in
// s_tuser and a value in s_tdata: load appends the value at the tail,
// reverse flips the logical direction, delete drops the logical front,
// and finish streams the held values in logical order (or a single empty,
// error or overflow status with tlast set) and then clears the buffer for
// the next case. Load, reverse and delete never produce an output transfer,
// so they keep flowing even while an earlier result waits in the output
// register. A finish holding values keeps s_tready low until the last value
// has moved into the output register: the values are fetched one per cycle,
// while the output side does not stall, through the single read port of the
// element store, whose read data is registered. A finish that reports a
// status keeps s_tready low until the status is placed in the output
// register. Loads into a full buffer are dropped and reported as overflow at
// the next finish; a delete on an empty buffer is reported as an error,
// which wins over overflow.
module reversible_deque_engine #(
  parameter int CAPACITY   = deq_pkg::DEF_CAPACITY,
  parameter int VALUE_BITS = deq_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [deq_pkg::ELEMENT_W-1:0] s_tdata,  // [15:0] value
  input  logic [deq_pkg::OP_W-1:0]      s_tuser,  // [1:0] operation
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [deq_pkg::ELEMENT_W-1:0] m_tdata,  // [15:0] element
  output logic [deq_pkg::STATUS_W-1:0]  m_tuser,  // [1:0] status
  output logic                          m_tlast
);
  import deq_pkg::*;

  // Only the low bits of a value that both the value mask and the
  // element field keep need storage.
  localparam int DATA_BITS = (VALUE_BITS < ELEMENT_W) ? VALUE_BITS : ELEMENT_W;
  localparam int AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  mem_ctl_t             mem_ctl;
  logic [AW-1:0]        wr_addr;
  logic [DATA_BITS-1:0] wr_data;
  logic [AW-1:0]        rd_addr;
  logic [DATA_BITS-1:0] rd_data;

  // Sequencer: pointers, direction and error flags, finish readout and
  // the output register.
  deq_ctrl #(
    .CAPACITY  (CAPACITY),
    .DATA_BITS (DATA_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .mem_ctl  (mem_ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  // Circular element store. A load writes at the edge it is accepted, and
  // the first readout of a finish is issued only once the controller is in
  // EMIT, after the finish is accepted, so no forwarding is needed.
  deq_store #(
    .CAPACITY  (CAPACITY),
    .DATA_BITS (DATA_BITS)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

>>> rtl/deq_checker.sv
module deq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [deq_pkg::OP_W-1:0]      s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [deq_pkg::ELEMENT_W-1:0] m_tdata,
  input logic [deq_pkg::STATUS_W-1:0]  m_tuser,
  input logic                          m_tlast
);
  import deq_pkg::*;

  // A status result is always alone in its run and carries no element.
  a_status_form: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_ELEMENT)) |-> (m_tlast && (m_tdata == '0)))
    else $error("status result without last or with nonzero element");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
    else $error("stalled result changed");

  // The cycle after a finish transfer no input is taken.
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == OP_FINISH)) |=> !s_tready)
    else $error("input taken right after finish");

  // While a run is still in progress no input is taken.
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !s_tready)
    else $error("input taken in the middle of a finish run");

endmodule

bind reversible_deque_engine deq_checker u_deq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

>>> sim/tb_reversible_deque_engine.sv
module tb_reversible_deque_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int DEPTH       = DEF_CAPACITY;
  localparam int STALL_LIMIT = 2000;      // cycles without any transfer before giving up
  localparam int TAIL_CYCLES = 2 * DEPTH; // quiet cycles after the last result
  localparam int PHASE_ITEMS = 4;         // minimum small-case items per idling phase

  // One output transfer as the block should present it.
  typedef struct packed {
    logic [ELEMENT_W-1:0] element;
    status_t              status;
    logic                 last;
  } deq_result_t;

  // Shadow copy of the deque. Every accepted input transfer is applied here,
  // and a finish turns the held content (or the pending status) into the
  // list of output transfers the block owes us.
  class deque_shadow;
    logic [ELEMENT_W-1:0] slots [DEPTH];
    logic [5:0]           head;
    logic [6:0]           count;
    bit                   reversed;
    bit                   error_seen;
    bit                   overflow_seen;
    deq_result_t          owed_q [$];
    int                   mismatches;
    int                   inputs_seen;
    int                   results_seen;
    int                   status_seen [4];

    function new();
      mismatches   = 0;
      inputs_seen  = 0;
      results_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      clear_case();
    endfunction

    function void clear_case();
      head          = '0;
      count         = '0;
      reversed      = 1'b0;
      error_seen    = 1'b0;
      overflow_seen = 1'b0;
    endfunction

    function int owed();
      return owed_q.size();
    endfunction

    function void push_result(logic [ELEMENT_W-1:0] element, status_t status, logic last);
      deq_result_t r;
      r.element = element;
      r.status  = status;
      r.last    = last;
      owed_q.insert(owed_q.size(), r);
    endfunction

    function void apply_op(op_t op, logic [ELEMENT_W-1:0] value);
      logic [6:0] off;
      logic [5:0] slot;
      inputs_seen++;
      case (op)
        OP_LOAD: begin
          if (count >= DEPTH) begin
            overflow_seen = 1'b1;
          end else begin
            slot = head + count[5:0];
            slots[slot] = value;
            count++;
          end
        end
        OP_REVERSE: begin
          reversed = !reversed;
        end
        OP_DELETE: begin
          // Once an error is latched, further deletes do nothing.
          if (!error_seen) begin
            if (count == 0) begin
              error_seen = 1'b1;
            end else begin
              if (!reversed) head = head + 6'd1;
              count--;
            end
          end
        end
        default: begin
          if (error_seen) begin
            push_result('0, ST_ERROR, 1'b1);
          end else if (overflow_seen) begin
            push_result('0, ST_OVERFLOW, 1'b1);
          end else if (count == 0) begin
            push_result('0, ST_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < int'(count); i++) begin
              off  = reversed ? (count - 7'd1 - 7'(i)) : 7'(i);
              slot = head + off[5:0];
              push_result(slots[slot], ST_ELEMENT, i == int'(count) - 1);
            end
          end
          clear_case();
        end
      endcase
    endfunction

    task report(string what);
      mismatches++;
      $display("MISMATCH %0d at %0t: %s", mismatches, $realtime, what);
    endtask

    task compare_out(logic [ELEMENT_W-1:0] element, status_t status, logic last);
      deq_result_t want;
      results_seen++;
      status_seen[status]++;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result element=%h status=%0d last=%0d",
                         element, status, last));
      end else begin
        want = owed_q[0];
        owed_q.delete(0);
        if (element !== want.element)
          report($sformatf("element %h, wanted %h", element, want.element));
        if (status !== want.status)
          report($sformatf("status %0d, wanted %0d", status, want.status));
        if (last !== want.last)
          report($sformatf("last %0d, wanted %0d", last, want.last));
      end
    endtask
  endclass

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [ELEMENT_W-1:0] s_tdata  = '0;
  logic [OP_W-1:0]      s_tuser  = OP_LOAD;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [ELEMENT_W-1:0] m_tdata;
  logic [STATUS_W-1:0]  m_tuser;
  logic                 m_tlast;

  // Percentages of cycles in which the sender and the receiver hold back.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;

  deque_shadow shadow = new();

  reversible_deque_engine #(
    .CAPACITY   (DEF_CAPACITY),
    .VALUE_BITS (DEF_VALUE_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: results are sampled at the rising edge, and tready is redrawn
  // at each falling edge according to the current idling rate.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        shadow.compare_out(m_tdata, status_t'(m_tuser), m_tlast);
      @(negedge clk);
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: a correct run never goes this long without a single transfer
  // on either side, even under the heaviest idling.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results still owed",
                 quiet, shadow.owed());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offer one item and hold it until the block takes it. Valid is lowered
  // only inside the idle loop, so it is never dropped and raised again in
  // the same time step between back-to-back items.
  task automatic send_item(op_t op, logic [ELEMENT_W-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    shadow.apply_op(op, value);
    items_sent++;
    @(negedge clk);
  endtask

  // Non-load operations carry random data, since the block must ignore it.
  task automatic send_op(op_t op);
    send_item(op, ELEMENT_W'($urandom_range(0, 65535)));
  endtask

  task automatic send_load();
    send_item(OP_LOAD, ELEMENT_W'($urandom_range(0, 65535)));
  endtask

  // Stop offering items until the block has delivered everything it owes.
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (shadow.owed() != 0);
  endtask

  // A short case. Most are well formed: loads with reverses and deletes
  // that never underflow. The rest are underflow errors, plain noise, or
  // cases with nothing loaded.
  task automatic run_small_case();
    int kind;
    int steps;
    int pick;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      steps = $urandom_range(1, 12);
      repeat (steps) begin
        pick = $urandom_range(0, 9);
        if (pick < 5 || shadow.count == 0) send_load();
        else if (pick < 7) send_op(OP_REVERSE);
        else send_op(OP_DELETE);
      end
      send_op(OP_FINISH);
    end else if (kind == 7) begin
      // Delete past empty, then keep loading and reversing: the error must
      // still be what the finish reports.
      steps = $urandom_range(0, 3);
      repeat (steps) send_load();
      repeat (steps + $urandom_range(1, 2)) send_op(OP_DELETE);
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 1)) send_load();
        else send_op(OP_REVERSE);
      end
      send_op(OP_FINISH);
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 10)) send_op(op_t'($urandom_range(0, 3)));
    end else begin
      repeat ($urandom_range(0, 3)) send_op(OP_REVERSE);
      send_op(OP_FINISH);
    end
  endtask

  // The long cases: a full buffer whose content wraps around the end of
  // the store, and a plain overflow.
  task automatic run_large_case(int which);
    case (which)
      0: begin
        repeat (DEPTH) send_load();
        send_op(OP_DELETE);
        send_load();
        if ($urandom_range(0, 1)) send_op(OP_REVERSE);
        send_op(OP_FINISH);
      end
      default: begin
        repeat (DEPTH + 1) send_load();
        send_op(OP_FINISH);
      end
    endcase
  endtask

  initial begin
    int phase_start;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 10;
    recv_idle_pct = 80;

    // Directed cases first. A finish on an empty buffer.
    send_op(OP_FINISH);
    // Value extremes, emitted in reversed order.
    send_item(OP_LOAD, 16'h0000);
    send_item(OP_LOAD, 16'hFFFF);
    send_item(OP_LOAD, 16'h5A5A);
    send_op(OP_REVERSE);
    send_op(OP_FINISH);
    // Delete from the head while forward, then from the tail once reversed.
    send_item(OP_LOAD, 16'h1234);
    send_item(OP_LOAD, 16'hABCD);
    send_op(OP_DELETE);
    send_op(OP_REVERSE);
    send_item(OP_LOAD, 16'h00FF);
    send_op(OP_DELETE);
    send_op(OP_FINISH);
    // Delete on empty, a second delete that is ignored, and ordinary
    // operations after the error.
    send_op(OP_DELETE);
    send_op(OP_DELETE);
    send_item(OP_LOAD, 16'h7777);
    send_op(OP_REVERSE);
    send_op(OP_FINISH);
    // Two reverses cancel out.
    send_op(OP_REVERSE);
    send_op(OP_REVERSE);
    send_item(OP_LOAD, 16'h8001);
    send_op(OP_FINISH);

    // Random cases under three idling patterns. Between phases the sender
    // waits until every owed result has been delivered.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 10; recv_idle_pct = 80; end
        1: begin send_idle_pct = 80; recv_idle_pct = 10; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_small_case();
      if (phase < 2) run_large_case(phase);
      // Close any case the noise left open so its content is checked too.
      send_op(OP_FINISH);
      hold_until_drained();
    end

    // All input is in: let the last results drain, then watch for strays.
    s_tvalid <= 1'b0;
    while (shadow.owed() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (shadow.owed() != 0)
      shadow.report($sformatf("%0d results never arrived", shadow.owed()));

    $display("covered %0d input transfers and %0d result transfers over three idling phases",
             shadow.inputs_seen, shadow.results_seen);
    $display("status results seen: empty %0d, error %0d, overflow %0d",
             shadow.status_seen[ST_EMPTY], shadow.status_seen[ST_ERROR],
             shadow.status_seen[ST_OVERFLOW]);
    if (shadow.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/deq_pkg.sv
rtl/deq_store.sv
rtl/deq_ctrl.sv
rtl/reversible_deque_engine.sv
rtl/deq_checker.sv
sim/tb_reversible_deque_engine.sv
